>>> hw/rtl/skf_pkg.sv
package skf_pkg;

    localparam int FRACTION_BITS = 16;

    localparam int EST_W  = 32;
    localparam int VAR_W  = 31;
    localparam int GAIN_W = 17;
    localparam int DEN_W  = VAR_W + 1;
    localparam int K_W    = FRACTION_BITS + 1;
    localparam int DIFF_W = EST_W + 1;
    localparam int PROD_W = K_W + 1 + DIFF_W;
    localparam int SH_W   = PROD_W - FRACTION_BITS;
    localparam int SUM_W  = SH_W + 1;
    localparam int CNT_W  = $clog2(K_W);
    localparam int GCMP_W = (K_W > GAIN_W) ? K_W : GAIN_W;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [K_W-1:0]    FIX_ONE      = K_W'(1) << FRACTION_BITS;
    localparam logic [VAR_W-1:0]  VAR_RESET    = VAR_W'(1) << FRACTION_BITS;
    localparam logic [VAR_W-1:0]  VAR_MAX      = '1;
    localparam logic [VAR_W-1:0]  Q_RESET      = VAR_W'(0);
    localparam logic [VAR_W-1:0]  R_RESET      = VAR_W'(65536);
    localparam logic [GAIN_W-1:0] GAIN_MAX     = '1;
    localparam logic [CNT_W-1:0]  DIV_LAST     = CNT_W'(K_W - 1);
    localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
    localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

    typedef enum logic {
        REG_PROCESS_NOISE,
        REG_MEAS_NOISE
    } skf_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MULX,
        ST_UPDX,
        ST_MULP,
        ST_UPDP,
        ST_DONE
    } skf_state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic mul_x;
        logic upd_x;
        logic mul_p;
        logic upd_p;
        logic out_load;
    } skf_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_busy;
    } skf_stat_t;

endpackage

>>> hw/rtl/skf_ctrl.sv
module skf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  skf_pkg::skf_stat_t stat,
    output skf_pkg::skf_cmd_t  cmd
);
    import skf_pkg::*;

    skf_state_t state_reg;
    skf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_MULX;
                end
            end
            ST_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = ST_UPDX;
            end
            ST_UPDX:
            begin
                cmd.upd_x  = 1'b1;
                state_next = ST_MULP;
            end
            ST_MULP:
            begin
                cmd.mul_p  = 1'b1;
                state_next = ST_UPDP;
            end
            ST_UPDP:
            begin
                cmd.upd_p  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register frees up
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");
`endif

endmodule

>>> hw/rtl/skf_dp.sv
module skf_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  skf_pkg::skf_cmd_t                   cmd,
    output skf_pkg::skf_stat_t                  stat,
    input  logic signed [skf_pkg::EST_W-1:0]    measurement,
    input  logic        [skf_pkg::VAR_W-1:0]    process_noise,
    input  logic        [skf_pkg::VAR_W-1:0]    measurement_noise,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [skf_pkg::EST_W-1:0]    estimate,
    output logic        [skf_pkg::GAIN_W-1:0]   gain
);
    import skf_pkg::*;

    // filter state
    logic signed [EST_W-1:0]  est_reg;
    logic        [VAR_W-1:0]  var_reg;

    // per-item working registers
    logic signed [EST_W-1:0]  z_reg;
    logic        [VAR_W-1:0]  p_reg;
    logic        [DEN_W-1:0]  den_reg;
    logic        [DEN_W-1:0]  rem_reg;
    logic                     nbit_reg;
    logic        [K_W-1:0]    quo_reg;
    logic        [CNT_W-1:0]  cnt_reg;
    logic        [K_W-1:0]    k_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // output register
    logic                     out_valid_reg;
    logic signed [EST_W-1:0]  est_out_reg;
    logic        [GAIN_W-1:0] gain_out_reg;

    logic [DEN_W:0]           var_sum;
    logic [VAR_W-1:0]         p_sat;
    logic [DEN_W:0]           trial;
    logic                     trial_ge;
    logic [DEN_W:0]           trial_sub;
    logic [K_W-1:0]           k_val;
    logic signed [DIFF_W-1:0] diff;
    logic [K_W-1:0]           mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [K_W:0]      mul_a_s;
    logic signed [SH_W-1:0]   prod_sh;
    logic signed [SUM_W-1:0]  est_sum;
    logic signed [EST_W-1:0]  est_clamp;
    logic [VAR_W-1:0]         var_sat;
    logic [GCMP_W-1:0]        gain_ext;
    logic [GAIN_W-1:0]        gain_sat;
    logic                     out_xfer;

    assign var_sum = (DEN_W+1)'(var_reg) + (DEN_W+1)'(process_noise);
    assign p_sat   = (var_sum[DEN_W:VAR_W] != '0) ? VAR_MAX : var_sum[VAR_W-1:0];

    // restoring division, one quotient bit per step
    assign trial     = {rem_reg, nbit_reg};
    assign trial_ge  = (trial >= {1'b0, den_reg});
    assign trial_sub = trial - {1'b0, den_reg};

    assign k_val = (den_reg == '0) ? '0 : quo_reg;
    assign diff  = DIFF_W'(z_reg) - DIFF_W'(est_reg);

    // one shared multiplier for both products
    always_comb
    begin
        if (cmd.mul_p)
        begin
            mul_a = FIX_ONE - k_reg;
            mul_b = {{(DIFF_W-VAR_W){1'b0}}, p_reg};
        end
        else
        begin
            mul_a = k_val;
            mul_b = diff;
        end
    end
    assign mul_a_s = {1'b0, mul_a};

    assign prod_sh = prod_reg[PROD_W-1:FRACTION_BITS];
    assign est_sum = SUM_W'(est_reg) + SUM_W'(prod_sh);

    always_comb
    begin
        priority if (est_sum > SUM_W'(EST_MAX))
        begin
            est_clamp = EST_MAX;
        end
        else if (est_sum < SUM_W'(EST_MIN))
        begin
            est_clamp = EST_MIN;
        end
        else
        begin
            est_clamp = est_sum[EST_W-1:0];
        end
    end

    assign var_sat = (prod_sh[SH_W-1:VAR_W] != '0) ? VAR_MAX : prod_sh[VAR_W-1:0];

    assign gain_ext = GCMP_W'(k_reg);
    assign gain_sat = (gain_ext > GCMP_W'(GAIN_MAX)) ? GAIN_MAX : gain_ext[GAIN_W-1:0];

    assign out_xfer = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg       <= '0;
            var_reg       <= VAR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd_x)
            begin
                est_reg <= est_clamp;
            end
            if (cmd.upd_p)
            begin
                var_reg <= var_sat;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            z_reg <= measurement;
            p_reg <= p_sat;
        end
        if (cmd.div_init)
        begin
            den_reg  <= DEN_W'(p_reg) + DEN_W'(measurement_noise);
            rem_reg  <= DEN_W'(p_reg[VAR_W-1:1]);
            nbit_reg <= p_reg[0];
            quo_reg  <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= trial_ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_reg  <= {quo_reg[K_W-2:0], trial_ge};
            nbit_reg <= 1'b0;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
        if (cmd.mul_x)
        begin
            k_reg <= k_val;
        end
        if (cmd.mul_x || cmd.mul_p)
        begin
            prod_reg <= mul_a_s * mul_b;
        end
        if (cmd.out_load)
        begin
            est_out_reg  <= est_reg;
            gain_out_reg <= gain_sat;
        end
    end

    assign stat.div_last = (cnt_reg == DIV_LAST);
    assign stat.out_busy = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign estimate  = est_out_reg;
    assign gain      = gain_out_reg;

`ifndef SYNTHESIS
    a_gain_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_x |=> (k_reg <= FIX_ONE))
        else $error("gain above one");

    a_var_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_p |=> (var_reg <= $past(p_reg)))
        else $error("error variance grew in the correction step");

    a_est_between: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd_x |=> (((est_reg >= $past(est_reg)) && (est_reg <= z_reg))
                    || ((est_reg <= $past(est_reg)) && (est_reg >= z_reg))))
        else $error("estimate left the range between old estimate and measurement");
`endif

endmodule

>>> hw/rtl/scalar_kalman_filter_fixed_top.sv
// Scalar Kalman filter, signed fixed point with FRACTION_BITS fraction bits.
// One item is in flight at a time: a new measurement is taken only in idle, after the last result
// has been loaded into the output register. The restoring divider for the gain forms one quotient
// bit per cycle over FRACTION_BITS+1 steps.
// Reset (rst_n, async, active low): estimate 0, error variance 1.0,
// process noise 0, measurement noise 1.0, no result pending.
module scalar_kalman_filter_fixed_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [skf_pkg::ADDR_W-1:0]   paddr,
    input  logic        [skf_pkg::DATA_W-1:0]   pwdata,
    output logic        [skf_pkg::DATA_W-1:0]   prdata,
    output logic                                pready,
    // measurement channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [skf_pkg::EST_W-1:0]    measurement,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [skf_pkg::EST_W-1:0]    estimate,
    output logic        [skf_pkg::GAIN_W-1:0]   gain
);
    import skf_pkg::*;

    logic [VAR_W-1:0] q_reg;
    logic [VAR_W-1:0] r_reg;
    skf_reg_t         reg_sel;
    logic             cfg_write;
    skf_cmd_t         cmd;
    skf_stat_t        stat;

    // registers sit at byte addresses 0 and 4; decode by the word index bit
    assign reg_sel   = skf_reg_t'(paddr[2]);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // drop the top data bit: both noise registers are 31 bits wide
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= Q_RESET;
            r_reg <= R_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_PROCESS_NOISE: q_reg <= pwdata[VAR_W-1:0];
                REG_MEAS_NOISE:    r_reg <= pwdata[VAR_W-1:0];
                default:           q_reg <= q_reg;
            endcase
        end
    end

    // read back the selected register, zero-extended
    always_comb
    begin
        unique case (reg_sel)
            REG_PROCESS_NOISE: prdata = DATA_W'(q_reg);
            REG_MEAS_NOISE:    prdata = DATA_W'(r_reg);
            default:           prdata = '0;
        endcase
    end

    // sequencer: accepts a transfer only when idle, then steps the datapath
    skf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: variance update, gain divider, shared multiplier, output register
    skf_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .measurement       (measurement),
        .process_noise     (q_reg),
        .measurement_noise (r_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .estimate          (estimate),
        .gain              (gain)
    );

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import skf_pkg::*;

    localparam int  HALF_PERIOD    = 4;
    localparam int  RESET_CYCLES   = 12;
    // Time from the measurement transfer to its result when the result side does not stall.
    localparam int  RESULT_LATENCY = FRACTION_BITS + 7;
    // Worst quiet stretch: long sender gap + one filter step + long result stall.
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  PHASE_COUNT    = 9;
    localparam int  PHASE_ITEMS    = 150;

    localparam longint UNITY      = longint'(1) << FRACTION_BITS;
    localparam longint VAR_CEIL   = longint'(VAR_MAX);
    localparam longint GAIN_CEIL  = longint'(GAIN_MAX);
    localparam longint EST_CEIL   = longint'(EST_MAX);
    localparam longint EST_FLOOR  = longint'(EST_MIN);

    typedef struct {
        logic signed [EST_W-1:0]  estimate;
        logic        [GAIN_W-1:0] gain;
    } filter_result_t;

    // DUT connections, all inputs known from time zero
    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [ADDR_W-1:0]          paddr       = '0;
    logic [DATA_W-1:0]          pwdata      = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    logic signed [EST_W-1:0]    measurement = '0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic signed [EST_W-1:0]    estimate;
    logic        [GAIN_W-1:0]   gain;

    // Filter state as the testbench tracks it, plus the noise settings
    longint                     track_estimate;
    longint                     track_variance;
    longint                     q_noise;
    longint                     r_noise;
    filter_result_t             pending_updates[$];

    // Control knobs and counters; calm is shared between the stimulus and the result stall generator
    logic                       calm        = 1'b0;
    int                         stall_hold  = 0;
    int                         idle_cycles = 0;
    int                         mismatch_count = 0;

    scalar_kalman_filter_fixed_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .estimate    (estimate),
        .gain        (gain)
    );

    always #HALF_PERIOD clk = ~clk;

    // One filter step: grow the variance, form the gain, pull the estimate
    // toward the measurement, shrink the variance. Queue the outcome.
    function automatic void advance_filter(input logic signed [EST_W-1:0] z);
        longint p;
        longint den;
        longint k;
        longint x;
        filter_result_t upd;
        p = track_variance + q_noise;
        if (p > VAR_CEIL)
            p = VAR_CEIL;
        den = p + r_noise;
        // zero denominator: gain stays zero and the estimate holds
        k = (den == 0) ? 0 : (p << FRACTION_BITS) / den;
        // arithmetic shift of a signed product floors toward minus infinity
        x = track_estimate + ((k * (longint'(z) - track_estimate)) >>> FRACTION_BITS);
        if (x > EST_CEIL)
            x = EST_CEIL;
        if (x < EST_FLOOR)
            x = EST_FLOOR;
        track_estimate = x;
        track_variance = ((UNITY - k) * p) >>> FRACTION_BITS;
        if (track_variance > VAR_CEIL)
            track_variance = VAR_CEIL;
        upd.estimate = x[EST_W-1:0];
        upd.gain     = (k > GAIN_CEIL) ? GAIN_CEIL[GAIN_W-1:0] : k[GAIN_W-1:0];
        pending_updates.push_back(upd);
    endfunction

    // Noise settings: extremes, tiny, moderate and full random words
    // (bit 31 set on purpose to check that only 31 bits are kept).
    function automatic logic [DATA_W-1:0] pick_noise();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return $urandom_range(1, 255);
            4, 5:    return $urandom_range(0, 1 << 20);
            default: return $urandom();
        endcase
    endfunction

    // Write a noise register over the config port, then read it back.
    task automatic program_noise(input skf_reg_t which, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] readback;
        logic [DATA_W-1:0] kept;
        kept = value & DATA_W'(VAR_CEIL);
        // setup phase of the write
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(which));
        pwdata  <= value;
        // access phase; the register takes the data when pready is seen high
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (which == REG_PROCESS_NOISE)
            q_noise = longint'(kept);
        else
            r_noise = longint'(kept);
        // back-to-back read: setup, then access
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== kept) begin
            $error("%s: expected %0h, got %0h", which.name(), kept, readback);
            mismatch_count++;
        end
    endtask

    // Offer one measurement after a random gap; hold it until the transfer.
    task automatic send_measurement(input logic signed [EST_W-1:0] z);
        int gap;
        int pick;
        gap = 0;
        if (!calm) begin
            pick = $urandom_range(0, 99);
            if (pick >= 90)
                gap = $urandom_range(10, 60);
            else if (pick >= 55)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= z;
        do @(posedge clk); while (in_stall);
        advance_filter(z);
    endtask

    // Drop the offer and hold off until every queued update has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
    endtask

    // Default noise after reset: q = 0, r = 1.0.
    task automatic test_reset_config();
        send_measurement(32'sd0);
        send_measurement(32'sd65536);
        send_measurement(-32'sd65536);
    endtask

    // Full-scale swings and alternating bit patterns in the measurement.
    task automatic test_measurement_extremes();
        send_measurement(EST_MAX);
        send_measurement(EST_MIN);
        send_measurement(EST_MAX);
        send_measurement(-32'sd1);
        send_measurement(32'sd1);
        send_measurement(32'sd0);
        send_measurement(32'sh5555_5555);
        send_measurement(32'shAAAA_AAAA);
    endtask

    // Maximum process noise drives the variance into saturation; vary r
    // from its smallest nonzero value to its largest.
    task automatic test_variance_saturation();
        drain_results();
        program_noise(REG_PROCESS_NOISE, 32'hFFFF_FFFF);
        program_noise(REG_MEAS_NOISE, 32'd1);
        send_measurement(EST_MAX);
        send_measurement(EST_MIN);
        send_measurement(32'sd0);
        drain_results();
        program_noise(REG_MEAS_NOISE, 32'h7FFF_FFFF);
        send_measurement(EST_MIN);
        send_measurement(EST_MAX);
    endtask

    // r = 0 with p > 0 gives a gain of exactly one; then q = 0 leaves p at
    // zero and the denominator vanishes, so the estimate holds.
    task automatic test_zero_measurement_noise();
        drain_results();
        program_noise(REG_MEAS_NOISE, 32'd0);
        program_noise(REG_PROCESS_NOISE, 32'd65536);
        send_measurement(32'sh1234_5678);
        send_measurement(-32'sh0765_4321);
        drain_results();
        program_noise(REG_PROCESS_NOISE, 32'd0);
        send_measurement(EST_MAX);
        send_measurement(EST_MIN);
        send_measurement(32'sd42);
    endtask

    // Random measurements over several noise settings; every fourth phase
    // runs without idling on either side.
    task automatic test_random_phases();
        longint near;
        logic signed [EST_W-1:0] z;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain_results();
            program_noise(REG_PROCESS_NOISE, pick_noise());
            program_noise(REG_MEAS_NOISE, pick_noise());
            calm <= (phase % 4 == 3);
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: z = $urandom();
                    5, 6: begin
                        // small step around the current estimate
                        near = track_estimate + longint'($urandom_range(0, 1 << 18))
                               - longint'(1 << 17);
                        if (near > EST_CEIL)
                            near = EST_CEIL;
                        if (near < EST_FLOOR)
                            near = EST_FLOOR;
                        z = near[EST_W-1:0];
                    end
                    7: z = $urandom_range(0, 1) ? EST_MAX : EST_MIN;
                    default: z = $urandom_range(0, 1 << 20) - (1 << 19);
                endcase
                send_measurement(z);
            end
        end
        calm <= 1'b0;
    endtask

    // Result side: stall in random bursts, mostly short, now and then long;
    // drop all stalls while the stimulus asks for a calm stretch.
    always @(posedge clk) begin : result_stall_gen
        int pick;
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (calm) begin
            out_stall <= 1'b0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                out_stall  <= 1'b0;
                stall_hold <= $urandom_range(0, 6);
            end else if (pick < 92) begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(0, 3);
            end else begin
                out_stall  <= 1'b1;
                stall_hold <= $urandom_range(10, 60);
            end
        end
    end

    // Compare every result transfer with the oldest queued update.
    always @(posedge clk) begin : result_check
        filter_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_updates.size() == 0) begin
                $error("estimate: expected nothing, got %0d (gain %0d)", estimate, gain);
                mismatch_count++;
            end else begin
                want = pending_updates.pop_front();
                if (estimate !== want.estimate) begin
                    $error("estimate: expected %0d, got %0d", want.estimate, estimate);
                    mismatch_count++;
                end
                if (gain !== want.gain) begin
                    $error("gain: expected %0d, got %0d", want.gain, gain);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk) begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        // reset state of the tracked filter and the noise registers
        track_estimate = 0;
        track_variance = longint'(VAR_RESET);
        q_noise        = longint'(Q_RESET);
        r_noise        = longint'(R_RESET);

        // hold reset, then release on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_config();
        test_measurement_extremes();
        test_variance_saturation();
        test_zero_measurement_noise();
        test_random_phases();

        // stop offering measurements, wait for the tail, then a little longer
        drain_results();
        repeat (2 * RESULT_LATENCY) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
